@@ src/stsq_pkg.sv @@
// Shared types and constants for the single-touch selection queue.
// No dependencies; imported by stsq_ring and single_touch_select_queue.
`default_nettype none

package stsq_pkg;

    typedef enum logic [1:0] {
        EV_DOWN   = 2'd0,
        EV_MOVE   = 2'd1,
        EV_UP     = 2'd2,
        EV_CANCEL = 2'd3
    } t_event;

    localparam logic ACT_REPORT = 1'b0;
    localparam logic ACT_POLL   = 1'b1;

    localparam int COORD_W = 15;
    localparam int ID_W    = 8;

    localparam logic REG_ENABLED = 1'b0;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               pressed;
        logic               cancel;
    } t_sample;

    typedef struct packed {
        logic    en;
        t_sample data;
    } t_ring_wr;

endpackage

`default_nettype wire

@@ src/single_touch_select_queue.sv @@
// Top level of the single-touch selection queue: input register, update logic,
// result register and the configuration port. Uses stsq_pkg and stsq_ring.
// The result strobe o_valid is registered twice: start sets r_in_valid, then r_out_valid.
// Throughput: one transaction per cycle; busy is always low. The sample ring
// keeps its head entry in a registered read port, so a poll takes it straight from that port.
// Reset clears all control state and the pointer; ring contents are not cleared.
`default_nettype none

module single_touch_select_queue import stsq_pkg::*; #(
    parameter int RING_DEPTH   = 32,
    parameter int FINGER_COUNT = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_action,
    input  wire logic [1:0]         i_event_kind,
    input  wire logic [ID_W-1:0]    i_touch_id,
    input  wire logic [COORD_W-1:0] i_touch_x,
    input  wire logic [COORD_W-1:0] i_touch_y,
    input  wire logic               i_contact_pressed,
    output logic                    o_valid,
    output logic [COORD_W-1:0]      o_point_x,
    output logic [COORD_W-1:0]      o_point_y,
    output logic                    o_pointer_pressed,
    output logic                    o_cancel_press,
    output logic                    o_more_pending,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int FW = (FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(RING_DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(RING_DEPTH);

    logic r_enabled;

    logic               r_in_valid;
    logic               r_action;
    t_event             r_kind;
    logic [ID_W-1:0]    r_id;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic               r_pressed_in;

    logic [IW-1:0]           r_head, n_head;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_sel_valid, n_sel_valid;
    logic [FW-1:0]           r_sel, n_sel;
    logic                    r_wait, n_wait;
    logic [FINGER_COUNT-1:0] r_mask, n_mask;
    t_sample                 r_cur, n_cur;
    logic                    r_last_pressed, n_last_pressed;
    logic                    r_last_cancel, n_last_cancel;
    logic                    r_prev_pressed, n_prev_pressed;

    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic               r_out_pressed;
    logic               r_out_cancel;
    logic               r_out_more;
    logic               n_cancel;

    t_ring_wr      ring_wr;
    logic [IW-1:0] ring_wr_addr;
    t_sample       head_data;

    logic          sel_v;
    logic [FW-1:0] sel_id;
    t_sample       smp;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] last_sum;
    logic [IW-1:0] tail_slot;
    logic [IW-1:0] last_slot;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
        end else if (cfg_wr && (paddr[2] == REG_ENABLED)) begin
            r_enabled <= pwdata[0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_ENABLED) begin
            prdata = {31'd0, r_enabled};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_action     <= i_action;
            r_kind       <= t_event'(i_event_kind);
            r_id         <= i_touch_id;
            r_x          <= i_touch_x;
            r_y          <= i_touch_y;
            r_pressed_in <= i_contact_pressed;
        end
    end

    always_comb begin
        tail_sum = SW'(r_head) + SW'(r_count);
        if (tail_sum >= DEPTH_S) begin
            tail_sum = tail_sum - DEPTH_S;
        end
        tail_slot = tail_sum[IW-1:0];
        last_sum  = SW'(r_head) + SW'(r_count - CW'(1));
        if (last_sum >= DEPTH_S) begin
            last_sum = last_sum - DEPTH_S;
        end
        last_slot = last_sum[IW-1:0];
    end

    always_comb begin
        n_head         = r_head;
        n_count        = r_count;
        n_sel_valid    = r_sel_valid;
        n_sel          = r_sel;
        n_wait         = r_wait;
        n_mask         = r_mask;
        n_cur          = r_cur;
        n_last_pressed = r_last_pressed;
        n_last_cancel  = r_last_cancel;
        n_prev_pressed = r_prev_pressed;
        n_cancel       = 1'b0;
        ring_wr        = '0;
        ring_wr_addr   = tail_slot;
        sel_v          = r_sel_valid;
        sel_id         = r_sel;
        smp            = '0;

        if (r_in_valid) begin
            if (r_action == ACT_REPORT) begin
                if (r_enabled && (r_id < ID_W'(FINGER_COUNT))) begin
                    if (r_kind inside {EV_DOWN, EV_MOVE}) begin
                        n_mask = r_mask | (FINGER_COUNT'(1) << r_id[FW-1:0]);
                    end else begin
                        n_mask = r_mask & ~(FINGER_COUNT'(1) << r_id[FW-1:0]);
                    end

                    if (r_wait) begin
                        if (n_mask == '0) begin
                            n_wait = 1'b0;
                        end
                    end else begin
                        if (!r_sel_valid && (r_kind == EV_DOWN)) begin
                            sel_v  = 1'b1;
                            sel_id = r_id[FW-1:0];
                        end
                        n_sel_valid = sel_v;
                        n_sel       = sel_id;

                        if (sel_v && (ID_W'(sel_id) == r_id)) begin
                            smp.x       = r_x;
                            smp.y       = r_y;
                            smp.pressed = r_pressed_in;
                            smp.cancel  = (r_kind == EV_CANCEL);
                            if (r_kind inside {EV_UP, EV_CANCEL}) begin
                                smp.pressed = 1'b0;
                                n_sel_valid = 1'b0;
                                n_wait      = (n_mask != '0);
                            end

                            if ((r_kind == EV_MOVE) && (r_count > CW'(1)) &&
                                r_last_pressed && r_prev_pressed && !r_last_cancel) begin
                                ring_wr.en     = 1'b1;
                                ring_wr.data   = smp;
                                ring_wr_addr   = last_slot;
                                n_last_pressed = smp.pressed;
                                n_last_cancel  = smp.cancel;
                            end else begin
                                if (r_count >= DEPTH_C) begin
                                    n_head       = '0;
                                    n_count      = CW'(1);
                                    n_sel_valid  = 1'b0;
                                    n_wait       = (n_mask != '0);
                                    smp.pressed  = 1'b0;
                                    smp.cancel   = 1'b1;
                                    ring_wr_addr = '0;
                                end else begin
                                    n_count      = r_count + CW'(1);
                                    ring_wr_addr = tail_slot;
                                end
                                ring_wr.en     = 1'b1;
                                ring_wr.data   = smp;
                                n_prev_pressed = r_last_pressed;
                                n_last_pressed = smp.pressed;
                                n_last_cancel  = smp.cancel;
                            end
                        end
                    end
                end
            end else if (r_count != '0) begin
                n_cur        = head_data;
                n_cur.cancel = 1'b0;
                n_cancel     = head_data.cancel;
                n_count      = r_count - CW'(1);
                if (r_head == LAST_IDX) begin
                    n_head = '0;
                end else begin
                    n_head = r_head + IW'(1);
                end
            end
        end
    end

    stsq_ring #(
        .DEPTH (RING_DEPTH),
        .IW    (IW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr      (ring_wr),
        .i_wr_addr (ring_wr_addr),
        .i_rd_addr (n_head),
        .o_rd_data (head_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head         <= '0;
            r_count        <= '0;
            r_sel_valid    <= 1'b0;
            r_sel          <= '0;
            r_wait         <= 1'b0;
            r_mask         <= '0;
            r_cur          <= '0;
            r_last_pressed <= 1'b0;
            r_last_cancel  <= 1'b0;
            r_prev_pressed <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_head         <= n_head;
            r_count        <= n_count;
            r_sel_valid    <= n_sel_valid;
            r_sel          <= n_sel;
            r_wait         <= n_wait;
            r_mask         <= n_mask;
            r_cur          <= n_cur;
            r_last_pressed <= n_last_pressed;
            r_last_cancel  <= n_last_cancel;
            r_prev_pressed <= n_prev_pressed;
            r_out_valid    <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out_x       <= n_cur.x;
            r_out_y       <= n_cur.y;
            r_out_pressed <= n_cur.pressed;
            r_out_cancel  <= n_cancel;
            r_out_more    <= (n_count != '0);
        end
    end

    assign o_valid           = r_out_valid;
    assign o_point_x         = r_out_x;
    assign o_point_y         = r_out_y;
    assign o_pointer_pressed = r_out_pressed;
    assign o_cancel_press    = r_out_cancel;
    assign o_more_pending    = r_out_more;

endmodule

`default_nettype wire

@@ src/stsq_ring.sv @@
// Sample ring storage with one write port and one registered read port.
// The read port always holds the entry at the next head, with write bypass. Uses stsq_pkg.
`default_nettype none

module stsq_ring import stsq_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int IW    = 5
) (
    input  wire logic          i_clk,
    input  wire t_ring_wr      i_wr,
    input  wire logic [IW-1:0] i_wr_addr,
    input  wire logic [IW-1:0] i_rd_addr,
    output t_sample            o_rd_data
);

    t_sample r_mem [DEPTH];
    t_sample r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr.data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire
